### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the force-capped update block.
// Needs nothing else; every macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/fcmp_pkg.sv
// Package of the force-capped momentum and position update block.
// Holds the fixed-point constants, the arctangent table and the shared types.
`timescale 1ns / 1ps
`default_nettype none

package fcmp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SQRT_STEPS = 32;
	localparam int CORDIC_STEPS = 31;
	localparam int DIV_STEPS = 32;

	localparam logic [30:0] PI_Q29 = 31'd1686629713;
	localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;

	localparam logic [1:0] CFG_VF = 2'd0;
	localparam logic [1:0] CFG_PF = 2'd1;
	localparam logic [1:0] CFG_CAP = 2'd2;

	typedef struct packed {
		logic [2:0][31:0] d;
		logic [2:0][31:0] mom;
		logic [2:0][31:0] pos;
		logic last;
	} item_t;

	typedef struct packed {
		logic [2:0][31:0] mom;
		logic [2:0][31:0] pos;
		logic last;
	} res_t;

	typedef struct packed {
		logic [31:0] vf;
		logic [31:0] pf;
		logic [30:0] cap;
	} cfg_t;

	function automatic logic [31:0] ang_tab(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h3243F6A8;
			1: v = 32'h1DAC6705;
			2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;
			4: v = 32'h03FEAB76;
			5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;
			7: v = 32'h007FFF55;
			8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000008;
			28: v = 32'h00000004;
			29: v = 32'h00000002;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	function automatic logic [31:0] sat32(input logic [65:0] v);
		if (!v[65] && (v[64:31] != '0)) begin
			return 32'h7FFFFFFF;
		end
		if (v[65] && (v[64:31] != '1)) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

### rtl/force_capped_momentum_position_update.sv
// Top level: configuration registers, the update pipeline and a skid output stage.
// Throughput is one atom per cycle while the skid stage is empty; the pipeline stalls
// while it holds a result. The depth comes from the 32-stage square root,
// the 31-stage CORDIC and the 32-stage dividers, one step per stage.
// Reset zeroes the config registers and empties the pipeline; there is no clearing pass.
// Depends on fcmp_pkg, fcmp_mag, fcmp_angle, fcmp_div, fcmp_update and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module force_capped_momentum_position_update (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// deriv_x, deriv_y, deriv_z, mom_x, mom_y, mom_z, pos_x, pos_y, pos_z
	input  wire logic [287:0] s_tdata,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// new_mom_x, new_mom_y, new_mom_z, new_pos_x, new_pos_y, new_pos_z
	output logic [191:0]      m_tdata,
	output logic              m_tlast,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata
);

	fcmp_pkg::cfg_t  cfg_q;
	fcmp_pkg::item_t in_item;

	logic            en;
	logic            mag_v, ang_v, div_v, upd_v;
	logic [31:0]     mag, ang_m, ang_mag;
	fcmp_pkg::item_t mag_item, ang_item, div_item;
	logic [2:0][32:0] div_d;
	fcmp_pkg::res_t  upd_res, out_q, skid_q;
	logic            out_v_q, skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcmp_pkg::CFG_VF: cfg_q.vf <= cfg_wdata;
				fcmp_pkg::CFG_PF: cfg_q.pf <= cfg_wdata;
				fcmp_pkg::CFG_CAP: cfg_q.cap <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_item.d[i] = s_tdata[32*i +: 32];
			in_item.mom[i] = s_tdata[96 + 32*i +: 32];
			in_item.pos[i] = s_tdata[192 + 32*i +: 32];
		end
		in_item.last = s_tlast;
	end

	assign en = !skid_v_q;
	assign s_tready = en;

	fcmp_mag u_mag (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid), .in_item(in_item),
		.out_valid(mag_v), .out_mag(mag), .out_item(mag_item)
	);

	fcmp_angle u_angle (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(mag_v), .in_mag(mag), .in_item(mag_item),
		.out_valid(ang_v), .out_m(ang_m), .out_mag(ang_mag), .out_item(ang_item)
	);

	fcmp_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(ang_v), .in_m(ang_m), .in_mag(ang_mag), .in_item(ang_item),
		.out_valid(div_v), .out_d(div_d), .out_item(div_item)
	);

	fcmp_update u_update (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(div_v), .in_d(div_d), .in_item(div_item),
		.out_valid(upd_v), .out_res(upd_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !m_tready) begin
			if (!skid_v_q && upd_v) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= upd_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !m_tready) begin
			if (!skid_v_q) begin
				skid_q <= upd_res;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= upd_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {out_q.pos[2], out_q.pos[1], out_q.pos[0],
		out_q.mom[2], out_q.mom[1], out_q.mom[0]};
	assign m_tlast = out_q.last;

	`ASSERT_IMPLY(a_skid_needs_out, clk, arst_n, skid_v_q, out_v_q)
	`ASSERT_IMPLY(a_skid_from_stall, clk, arst_n, $rose(skid_v_q), $past(out_v_q && !m_tready))
	`ASSERT_NEXT(a_out_held, clk, arst_n, out_v_q && !m_tready, out_v_q)
	`ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_v_q && m_tready, out_v_q && !skid_v_q)

endmodule

`default_nettype wire

### rtl/fcmp_mag.sv
// Magnitude stages: squares, sum and a one-bit-per-stage integer square root.
// Depends on fcmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcmp_mag (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire fcmp_pkg::item_t in_item,
	output logic                out_valid,
	output logic [31:0]         out_mag,
	output fcmp_pkg::item_t     out_item
);

	localparam int N = fcmp_pkg::SQRT_STEPS;

	logic [2:0][63:0] sq_s1;
	logic             v_s1;
	fcmp_pkg::item_t  item_s1;

	logic [63:0]      n_s [0:N];
	logic [63:0]      r_s [0:N];
	logic             v_s [0:N];
	fcmp_pkg::item_t  item_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= 64'(fcmp_pkg::abs32(in_item.d[i])) *
					64'(fcmp_pkg::abs32(in_item.d[i]));
			end
			item_s1 <= in_item;
			n_s[0] <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			r_s[0] <= '0;
			item_s[0] <= item_s1;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = r_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (n_s[k] >= trial) begin
					n_s[k+1] <= n_s[k] - trial;
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					n_s[k+1] <= n_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
				item_s[k+1] <= item_s[k];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_mag = r_s[N][31:0];
	assign out_item = item_s[N];

endmodule

`default_nettype wire

### rtl/fcmp_angle.sv
// Angle stages: operand scaling, normalization, CORDIC vectoring and capped magnitude.
// Depends on fcmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcmp_angle (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire fcmp_pkg::cfg_t cfg,
	input  wire logic           in_valid,
	input  wire logic [31:0]    in_mag,
	input  wire fcmp_pkg::item_t in_item,
	output logic                out_valid,
	output logic [31:0]         out_m,
	output logic [31:0]         out_mag,
	output fcmp_pkg::item_t     out_item
);

	localparam int N = fcmp_pkg::CORDIC_STEPS;

	logic [63:0] x_s1, y_s1, x_s2, y_s2;
	logic [31:0] mag_s1, mag_s2;
	logic        v_s1, v_s2;
	fcmp_pkg::item_t item_s1, item_s2;

	logic signed [63:0] cx_s [0:N];
	logic signed [63:0] cy_s [0:N];
	logic signed [31:0] cz_s [0:N];
	logic [31:0]        mag_s [0:N];
	logic               v_s [0:N];
	fcmp_pkg::item_t    item_s [0:N];

	logic [30:0] t_s4;
	logic [31:0] m_s5, mag_s4, mag_s5;
	logic        v_s4, v_s5;
	fcmp_pkg::item_t item_s4, item_s5;

	logic [63:0] xa, ya, xb, yb;
	logic [30:0] theta;

	always_comb begin
		xa = x_s1;
		ya = y_s1;
		if ((xa | ya) >> 32 == 64'd0) begin
			xa = xa << 32;
			ya = ya << 32;
		end
		if ((xa | ya) >> 48 == 64'd0) begin
			xa = xa << 16;
			ya = ya << 16;
		end
		if ((xa | ya) >> 56 == 64'd0) begin
			xa = xa << 8;
			ya = ya << 8;
		end
	end

	always_comb begin
		xb = x_s2;
		yb = y_s2;
		if ((xb | yb) >> 60 == 64'd0) begin
			xb = xb << 4;
			yb = yb << 4;
		end
		if ((xb | yb) >> 62 == 64'd0) begin
			xb = xb << 2;
			yb = yb << 2;
		end
		if ((xb | yb) >> 63 == 64'd0) begin
			xb = xb << 1;
			yb = yb << 1;
		end
		xb = xb >> 6;
		yb = yb >> 6;
	end

	assign theta = cz_s[N][31] ? 31'd0 : cz_s[N][30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s[0] <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s[0] <= v_s2;
			v_s4 <= v_s[N];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= 64'(in_mag) * 64'(fcmp_pkg::PI_Q29);
			x_s1 <= {3'b000, cfg.cap, 30'd0};
			mag_s1 <= in_mag;
			item_s1 <= in_item;
			x_s2 <= xa;
			y_s2 <= ya;
			mag_s2 <= mag_s1;
			item_s2 <= item_s1;
			cx_s[0] <= xb;
			cy_s[0] <= yb;
			cz_s[0] <= '0;
			mag_s[0] <= mag_s2;
			item_s[0] <= item_s2;
			t_s4 <= 31'((61'(theta) * 61'(fcmp_pkg::TWO_OVER_PI_Q30)) >> 30);
			mag_s4 <= mag_s[N];
			item_s4 <= item_s[N];
			m_s5 <= 32'((62'(cfg.cap) * 62'(t_s4)) >> 30);
			mag_s5 <= mag_s4;
			item_s5 <= item_s4;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic signed [31:0] ANG = fcmp_pkg::ang_tab(i);
		logic signed [63:0] xs, ys;
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][63]) begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + ANG;
				end else begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - ANG;
				end
				mag_s[i+1] <= mag_s[i];
				item_s[i+1] <= item_s[i];
			end
		end
	end

	assign out_valid = v_s5;
	assign out_m = m_s5;
	assign out_mag = mag_s5;
	assign out_item = item_s5;

endmodule

`default_nettype wire

### rtl/fcmp_div.sv
// Component scaling: three restoring dividers, one quotient bit per stage.
// Depends on fcmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcmp_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire fcmp_pkg::cfg_t cfg,
	input  wire logic           in_valid,
	input  wire logic [31:0]    in_m,
	input  wire logic [31:0]    in_mag,
	input  wire fcmp_pkg::item_t in_item,
	output logic                out_valid,
	output logic [2:0][32:0]    out_d,
	output fcmp_pkg::item_t     out_item
);

	localparam int N = fcmp_pkg::DIV_STEPS;

	logic [2:0][31:0] rem_s [0:N];
	logic [2:0][31:0] low_s [0:N];
	logic [2:0][31:0] quo_s [0:N];
	logic [31:0]      mag_s [0:N];
	logic             v_s [0:N];
	fcmp_pkg::item_t  item_s [0:N];

	logic [2:0][32:0] d_so;
	logic             v_so;
	fcmp_pkg::item_t  item_so;

	logic [2:0][63:0] prod;
	logic             bypass;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			prod[l] = 64'(fcmp_pkg::abs32(in_item.d[l])) * 64'(in_m);
		end
	end

	assign bypass = (cfg.cap == '0) || (mag_s[N] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
			v_so <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			v_so <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= prod[l][63:32];
				low_s[0][l] <= prod[l][31:0];
				quo_s[0][l] <= '0;
				if (bypass) begin
					d_so[l] <= {item_s[N].d[l][31], item_s[N].d[l]};
				end else if (item_s[N].d[l][31]) begin
					d_so[l] <= 33'(-{1'b0, quo_s[N][l]});
				end else begin
					d_so[l] <= {1'b0, quo_s[N][l]};
				end
			end
			mag_s[0] <= in_mag;
			item_s[0] <= in_item;
			item_so <= item_s[N];
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [32:0] tr;
			assign tr = {rem_s[k][l], low_s[k][l][31]};

			always_ff @(posedge clk) begin
				if (en) begin
					if (tr >= {1'b0, mag_s[k]}) begin
						rem_s[k+1][l] <= 32'(tr - {1'b0, mag_s[k]});
						quo_s[k+1][l] <= {quo_s[k][l][30:0], 1'b1};
					end else begin
						rem_s[k+1][l] <= tr[31:0];
						quo_s[k+1][l] <= {quo_s[k][l][30:0], 1'b0};
					end
					low_s[k+1][l] <= {low_s[k][l][30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s[k+1] <= mag_s[k];
				item_s[k+1] <= item_s[k];
			end
		end
	end

	assign out_valid = v_so;
	assign out_d = d_so;
	assign out_item = item_so;

endmodule

`default_nettype wire

### rtl/fcmp_update.sv
// Momentum and position update with saturation, two multiply stages.
// Depends on fcmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcmp_update (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire fcmp_pkg::cfg_t cfg,
	input  wire logic           in_valid,
	input  wire logic [2:0][32:0] in_d,
	input  wire fcmp_pkg::item_t in_item,
	output logic                out_valid,
	output fcmp_pkg::res_t      out_res
);

	localparam int F = fcmp_pkg::FRAC_BITS;

	logic signed [2:0][64:0] pr_s1;
	logic [2:0][31:0]        p_s2, p_s3, p_s4, q_s4;
	logic signed [2:0][63:0] pr_s3;
	logic                    v_s1, v_s2, v_s3, v_s4;
	fcmp_pkg::item_t         item_s1, item_s2, item_s3;
	logic                    last_s4;

	logic [2:0][64:0] sh1;
	logic [2:0][63:0] sh3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh1[i] = $signed(pr_s1[i]) >>> F;
			sh3[i] = $signed(pr_s3[i]) >>> F;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pr_s1[i] <= $signed(cfg.vf) * $signed(in_d[i]);
				p_s2[i] <= fcmp_pkg::sat32({{34{item_s1.mom[i][31]}}, item_s1.mom[i]} -
					{sh1[i][64], sh1[i]});
				pr_s3[i] <= $signed(cfg.pf) * $signed(p_s2[i]);
				q_s4[i] <= fcmp_pkg::sat32({{34{item_s3.pos[i][31]}}, item_s3.pos[i]} +
					{{2{sh3[i][63]}}, sh3[i]});
			end
			item_s1 <= in_item;
			item_s2 <= item_s1;
			p_s3 <= p_s2;
			item_s3 <= item_s2;
			p_s4 <= p_s3;
			last_s4 <= item_s3.last;
		end
	end

	assign out_valid = v_s4;
	assign out_res.mom = p_s4;
	assign out_res.pos = q_s4;
	assign out_res.last = last_s4;

endmodule

`default_nettype wire

### verif/force_capped_momentum_position_update_tb.sv
// Self-checking testbench for force_capped_momentum_position_update.
// Drives atoms through the stream ports, predicts each update in fixed point and checks
// the results in order; depends only on fcmp_pkg and the block itself.
`timescale 1ns / 1ps

module force_capped_momentum_position_update_tb;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1700;
	localparam int PHASES = 8;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;

	typedef struct {
		fcmp_pkg::item_t atom;
		bit typed;
		fcmp_pkg::res_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [287:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	longint vf_model, pf_model;
	longint unsigned cap_q;

	fcmp_pkg::res_t pending_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit hold_go = 1'b0;
	bit hold_seen = 1'b0;
	int hold_cnt = 0;

	force_capped_momentum_position_update dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	initial begin
		#(12.0 * 400000);
		$display("FAIL");
		$finish;
	end

	function automatic longint sx32(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic longint atan_q30(longint unsigned ux, longint unsigned uy);
		longint unsigned big;
		longint x, y, z, xs, ys;
		big = (ux > uy) ? ux : uy;
		while (big >= (64'd1 << 58)) begin
			ux = ux >> 1; uy = uy >> 1; big = big >> 1;
		end
		while (big < (64'd1 << 57)) begin
			ux = ux << 1; uy = uy << 1; big = big << 1;
		end
		x = longint'(ux);
		y = longint'(uy);
		z = 0;
		for (int i = 0; i < fcmp_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(fcmp_pkg::ang_tab(i));
			end else begin
				x -= ys; y += xs; z -= longint'(fcmp_pkg::ang_tab(i));
			end
		end
		return (z < 0) ? 0 : z;
	endfunction

	function automatic fcmp_pkg::res_t update_atom(fcmp_pkg::item_t a);
		fcmp_pkg::res_t r;
		longint d[3];
		longint unsigned sq, mag, t, m, mag_abs;
		longint theta, p;
		for (int i = 0; i < 3; i++) d[i] = sx32(a.d[i]);
		if (cap_q != 0) begin
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				mag_abs = longint'(d[i] < 0 ? -d[i] : d[i]);
				sq += mag_abs * mag_abs;
			end
			mag = int_sqrt(sq);
			if (mag != 0) begin
				theta = atan_q30(cap_q << 30, mag * 64'(fcmp_pkg::PI_Q29));
				t = longint'((theta * longint'(fcmp_pkg::TWO_OVER_PI_Q30)) >>> 30);
				m = (cap_q * t) >> 30;
				for (int i = 0; i < 3; i++) begin
					mag_abs = longint'(d[i] < 0 ? -d[i] : d[i]);
					p = longint'((mag_abs * m) / mag);
					d[i] = (d[i] < 0) ? -p : p;
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			p = clamp32(sx32(a.mom[i]) - ((vf_model * d[i]) >>> fcmp_pkg::FRAC_BITS));
			r.mom[i] = p[31:0];
			p = clamp32(sx32(a.pos[i]) + ((pf_model * p) >>> fcmp_pkg::FRAC_BITS));
			r.pos[i] = p[31:0];
		end
		r.last = a.last;
		return r;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fcmp_pkg::CFG_VF) vf_model = sx32(val);
		else if (idx == fcmp_pkg::CFG_PF) pf_model = sx32(val);
		else if (idx == fcmp_pkg::CFG_CAP) cap_q = {33'd0, val[30:0]};
		@(posedge clk);
	endtask

	task automatic set_config(logic [31:0] vf, logic [31:0] pf, logic [31:0] cap);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(fcmp_pkg::CFG_VF, vf);
		write_reg(fcmp_pkg::CFG_PF, pf);
		write_reg(fcmp_pkg::CFG_CAP, cap);
	endtask

	task automatic send_atom(fcmp_pkg::item_t a, bit typed, fcmp_pkg::res_t res);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {a.pos, a.mom, a.d};
		s_tlast <= a.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_q.push_back(typed ? res : update_atom(a));
	endtask

	function automatic logic [31:0] rand_word();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'(signed'($urandom_range(65535)) - 32768);
			3, 4: return 32'(signed'($urandom_range(32'h00FFFFFF)) - 32'sh007FFFFF);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_factor();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return ONE_Q;
			3: return 32'(signed'($urandom_range(32'h0003FFFF)) - 32'sh0001FFFF);
			default: return $urandom();
		endcase
	endfunction

	function automatic fcmp_pkg::item_t rand_atom();
		fcmp_pkg::item_t a;
		for (int i = 0; i < 3; i++) begin
			a.d[i] = rand_word();
			a.mom[i] = rand_word();
			a.pos[i] = rand_word();
		end
		a.last = 1'($urandom_range(1));
		return a;
	endfunction

	function automatic fcmp_pkg::item_t mk(logic [31:0] d, logic [31:0] mo, logic [31:0] po,
		logic l);
		fcmp_pkg::item_t a;
		a.d = {d, d, d};
		a.mom = {mo, 32'(-mo), mo};
		a.pos = {po, po, 32'(-po)};
		a.last = l;
		return a;
	endfunction

	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_cnt <= 400;
			m_tready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		fcmp_pkg::res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.mom = m_tdata[95:0];
			got.pos = m_tdata[191:96];
			got.last = m_tlast;
			results_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected transaction: %h", m_tdata);
			end else begin
				want = pending_q.pop_front();
				if (got.mom != want.mom || got.pos != want.pos || got.last != want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch mom exp %h got %h", want.mom, got.mom);
						$display("         pos exp %h got %h", want.pos, got.pos);
						$display("         last exp %b got %b", want.last, got.last);
					end
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		fcmp_pkg::res_t none;
		int phase_items;
		vf_model = 0;
		pf_model = 0;
		cap_q = 0;
		none = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// With all registers at reset the atom passes through unchanged.
		r.typed = 1'b1;
		r.atom = mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000001, 1'b0);
		rows.push_back(r);
		r.atom = mk(32'h80000000, 32'h00000000, 32'h7FFFFFFF, 1'b1);
		rows.push_back(r);
		r.atom = mk(32'h00000000, 32'h12345678, 32'h00010000, 1'b0);
		rows.push_back(r);
		foreach (rows[i]) begin
			rows[i].res.mom = rows[i].atom.mom;
			rows[i].res.pos = rows[i].atom.pos;
			rows[i].res.last = rows[i].atom.last;
		end
		foreach (rows[i]) send_atom(rows[i].atom, rows[i].typed, rows[i].res);
		s_tvalid <= 1'b0;

		// Unused register index must be ignored.
		while (pending_q.size() != 0) @(posedge clk);
		write_reg(CFG_UNUSED, 32'hFFFFFFFF);
		rows.delete();
		r.typed = 1'b0;
		r.res = none;
		r.atom = mk(32'h00000000, 32'h00000000, 32'h00000000, 1'b0);
		rows.push_back(r);
		r.atom = mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1);
		rows.push_back(r);
		r.atom = mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
		rows.push_back(r);
		r.atom = mk(32'h00010000, 32'h00008000, 32'hFFFF0000, 1'b0);
		rows.push_back(r);
		r.atom = mk(32'hFFFFFFFF, 32'h00000001, 32'h00000001, 1'b1);
		rows.push_back(r);
		r.atom = mk(32'h00000001, 32'hFFFFFFFF, 32'h40000000, 1'b0);
		rows.push_back(r);

		// Soft cap at one, unit factors.
		set_config(ONE_Q, ONE_Q, ONE_Q);
		foreach (rows[i]) send_atom(rows[i].atom, 1'b0, none);
		s_tvalid <= 1'b0;
		// Cap off with extreme factors drives saturation.
		set_config(32'h80000000, 32'h7FFFFFFF, 32'h00000000);
		foreach (rows[i]) send_atom(rows[i].atom, 1'b0, none);
		s_tvalid <= 1'b0;
		// Largest cap, written with bit 31 set, and the opposite extremes.
		set_config(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
		foreach (rows[i]) send_atom(rows[i].atom, 1'b0, none);
		s_tvalid <= 1'b0;
		// Smallest nonzero cap.
		set_config(32'hFFFF0000, 32'h00000001, 32'h00000001);
		foreach (rows[i]) send_atom(rows[i].atom, 1'b0, none);
		s_tvalid <= 1'b0;

		phase_items = RANDOM_ITEMS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			set_config(rand_factor(), rand_factor(),
				($urandom_range(3) == 0) ? 32'd0 : rand_factor());
			case (ph % 4)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 46; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 46; end
				default: begin src_idle_pct = 24; snk_stall_pct = 24; end
			endcase
			for (int n = 0; n < phase_items; n++) begin
				if (ph == 0 && n == 20) hold_go = ~hold_go;
				send_atom(rand_atom(), 1'b0, none);
			end
			s_tvalid <= 1'b0;
		end

		while (pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Checked %0d results over capped, uncapped and saturating settings,", results_seen);
		$display("with source gaps, sink stalls and one long output hold-off.");
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/fcmp_pkg.sv
rtl/fcmp_mag.sv
rtl/fcmp_angle.sv
rtl/fcmp_div.sv
rtl/fcmp_update.sv
rtl/force_capped_momentum_position_update.sv
verif/force_capped_momentum_position_update_tb.sv
